@@ sv/b64d_pkg.sv @@
// Package for the base64 decoder: queue entry type, queue sizing and the
// character-to-sextet map. No dependencies.
package b64d_pkg;

  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_DEPTH = 1 << Q_AW;

  // One queue entry: the results caused by one input item.
  typedef struct packed {
    logic [23:0] word;          // bytes, first result most significant
    logic [1:0]  nres;          // number of results, 1..3
    logic        byte_present;  // 0 for a bare end marker
    logic        done;          // last result of the entry closes the message
  } b64d_entry_t;

  // Bit 6 set: not in the alphabet (padding included).
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5a]}) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7a]}) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

@@ sv/base64_decoder.sv @@
// Top level of the streaming base64 decoder.
// Instantiates b64d_front, b64d_queue and b64d_back; depends on b64d_pkg.
//
// One character is taken per cycle while the four-entry result queue has
// room; every fourth alphabet character, and the end item of a message,
// leaves one entry holding one to three results. Results leave at one per
// cycle when not stalled, through a registered output, so sustained input
// runs at one item per cycle until the stream yields more than one result
// per cycle, and then at the output rate (three results per group of four
// characters keeps pace). The first '=' or non-alphabet byte halts decoding
// until the message ends; the end item always yields a result flagged
// message_done, a bare marker with byte_present low when no byte remains.
module base64_decoder import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_char_present,
  input  logic       in_message_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_present,
  output logic       out_message_done
);

  logic        accept, push, pop, full, empty;
  b64d_entry_t push_entry, head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  b64d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .char_code    (in_char_code),
    .char_present (in_char_present),
    .message_end  (in_message_end),
    .push         (push),
    .push_entry   (push_entry)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  b64d_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_message_done (out_message_done)
  );

endmodule

@@ sv/b64d_front.sv @@
// Front end of the base64 decoder: classifies each character, keeps the open
// group and the halt flag, and pushes one queue entry per item that has results.
// Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  char_code,
  input  logic        char_present,
  input  logic        message_end,
  output logic        push,
  output b64d_entry_t push_entry
);

  logic [17:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        halted_r, halted_nxt;
  logic [6:0]  sx;
  logic        group_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      cnt_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_comb begin
    sx         = sextet_of(char_code);
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    halted_nxt = halted_r;
    group_done = 1'b0;
    push       = 1'b0;
    push_entry = '0;

    if (accept && char_present && !halted_r) begin
      if (sx[6]) begin
        halted_nxt = 1'b1;
      end else if (cnt_r == 2'd3) begin
        group_done              = 1'b1;
        push                    = 1'b1;
        push_entry.word         = {pend_r, sx[5:0]};
        push_entry.nres         = 2'd3;
        push_entry.byte_present = 1'b1;
        pend_nxt                = '0;
        cnt_nxt                 = '0;
      end else begin
        pend_nxt = {pend_r[11:0], sx[5:0]};
        cnt_nxt  = cnt_r + 2'd1;
      end
    end

    if (accept && message_end) begin
      push            = 1'b1;
      push_entry.done = 1'b1;
      if (!group_done) begin
        if (cnt_nxt == 2'd3) begin
          push_entry.word         = {pend_nxt, 6'd0};
          push_entry.nres         = 2'd2;
          push_entry.byte_present = 1'b1;
        end else if (cnt_nxt == 2'd2) begin
          push_entry.word         = {pend_nxt[11:0], 12'd0};
          push_entry.nres         = 2'd1;
          push_entry.byte_present = 1'b1;
        end else begin
          // bare end marker
          push_entry.word         = '0;
          push_entry.nres         = 2'd1;
          push_entry.byte_present = 1'b0;
        end
      end
      pend_nxt   = '0;
      cnt_nxt    = '0;
      halted_nxt = 1'b0;
    end
  end

endmodule

@@ sv/b64d_queue.sv @@
// Short register queue between the decoder front and back ends.
// Depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  b64d_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        empty,
  output b64d_entry_t head
);

  b64d_entry_t     mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r, count_nxt;

  assign full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue pop while empty");

endmodule

@@ sv/b64d_back.sv @@
// Back end of the base64 decoder: walks the head queue entry one result at a
// time into the output register. Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        empty,
  input  b64d_entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_present,
  output logic        out_message_done
);

  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       present_r, done_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load, last;

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_byte_present = present_r;
  assign out_message_done = done_r;

  always_comb begin
    load = !empty && (!valid_r || !out_stall);
    last = (idx_r == head.nres - 2'd1);
    pop  = load && last;
    case (idx_r)
      2'd0:    byte_nxt = head.word[23:16];
      2'd1:    byte_nxt = head.word[15:8];
      default: byte_nxt = head.word[7:0];
    endcase
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= byte_nxt;
      present_r <= head.byte_present;
      done_r    <= head.done && last;
    end
  end

  a_idx_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (idx_r < head.nres))
    else $error("result index beyond entry");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !present_r) |-> (byte_r == 8'd0 && done_r))
    else $error("end marker carries data or lacks done");

  a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == 2'd0))
    else $error("result index not cleared after pop");

endmodule
